[hdl/se_pkg.sv]
package se_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  typedef logic [IW-1:0]       idx_t;
  typedef logic [CW-1:0]       cnt_t;
  typedef logic signed [31:0]  word_t;

  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_INS_BOTTOM = 3'd2,
    OP_INS_SORTED = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_SORT       = 3'd5,
    OP_READ_MID   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_PUSH,
    CC_SHIFT_UP,
    CC_TAG,
    CC_SORT,
    CC_REV,
    CC_INS
  } ccmd_t;

  typedef struct packed {
    ccmd_t cmd;
    logic  phase;
    logic  set_mov;
    cnt_t  count;
    word_t value;
  } cell_ctl_t;

  typedef struct packed {
    word_t data;
    idx_t  tag;
    logic  mov;
  } cell_nb_t;

endpackage

[hdl/se_cell.sv]
module se_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  se_pkg::cell_ctl_t ctl,
  input  se_pkg::idx_t     idx,
  input  se_pkg::cell_nb_t lo,
  input  se_pkg::cell_nb_t hi,
  input  se_pkg::cnt_t     rd_idx,
  output se_pkg::cell_nb_t me,
  output se_pkg::word_t    rd_data
);

  se_pkg::word_t data_r, data_nxt;
  se_pkg::idx_t  tag_r, tag_nxt;
  logic          mov_r, mov_nxt;

  se_pkg::cnt_t  pos;
  se_pkg::cnt_t  pos_up;
  logic          in_lo;
  logic          in_hi;
  logic          am_lower;

  assign pos      = se_pkg::CW'(idx);
  assign pos_up   = pos + 1'b1;
  assign in_lo    = (pos != '0) && (pos < ctl.count);
  assign in_hi    = (pos_up < ctl.count);
  assign am_lower = (idx[0] == ctl.phase);

  assign me      = '{data: data_r, tag: tag_r, mov: mov_r};
  assign rd_data = (pos == rd_idx) ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    tag_nxt  = tag_r;
    mov_nxt  = mov_r;
    unique case (ctl.cmd)
      se_pkg::CC_HOLD: begin
      end
      se_pkg::CC_PUSH: begin
        mov_nxt = 1'b0;
        if (pos == ctl.count) begin
          data_nxt = ctl.value;
          mov_nxt  = ctl.set_mov;
        end
      end
      se_pkg::CC_SHIFT_UP: begin
        data_nxt = (pos == '0) ? ctl.value : lo.data;
      end
      se_pkg::CC_TAG: begin
        tag_nxt = idx;
      end
      se_pkg::CC_SORT: begin
        if (am_lower) begin
          if (in_hi && ($signed(data_r) > $signed(hi.data))) begin
            data_nxt = hi.data;
            tag_nxt  = hi.tag;
          end
        end else begin
          if (in_lo && ($signed(lo.data) > $signed(data_r))) begin
            data_nxt = lo.data;
            tag_nxt  = lo.tag;
          end
        end
      end
      se_pkg::CC_REV: begin
        if (am_lower) begin
          if (in_hi && (tag_r < hi.tag)) begin
            data_nxt = hi.data;
            tag_nxt  = hi.tag;
          end
        end else begin
          if (in_lo && (lo.tag < tag_r)) begin
            data_nxt = lo.data;
            tag_nxt  = lo.tag;
          end
        end
      end
      se_pkg::CC_INS: begin
        if (mov_r && in_lo && ($signed(lo.data) >= $signed(data_r))) begin
          data_nxt = lo.data;
          mov_nxt  = 1'b0;
        end else if (hi.mov && in_hi && ($signed(data_r) >= $signed(hi.data))) begin
          data_nxt = hi.data;
          mov_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mov_r <= 1'b0;
    end else begin
      mov_r <= mov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tag_r  <= tag_nxt;
  end

endmodule

[hdl/stack_engine_with_sort_and_reverse_top.sv]
// Bounded stack of signed 32-bit words, held in a row of cells, one entry per cell.
// Input: an operation word is taken at a clock edge with start high and busy low.
//   Operations: push, pop, insert at bottom, insert in sorted place, reverse,
//   sort and read middle; the value port matters for push and the inserts.
// Output: one result word per operation, shown for exactly one cycle with
//   out_valid high; it carries the read value, a status and the fill count.
//   The receiver cannot stall, so the word must be taken in that cycle.
// Busy and result:
//   push, pop, insert at bottom, read middle, full or empty cases: result in
//   the cycle after the accept, and a new word can be taken in that cycle.
//   sort and reverse: busy while the cells run n rounds of odd-even neighbor
//   exchanges, n the fill count, so n is at most 16 rounds here.
//   sorted insert: the new word is pushed on top, then moves down one cell per
//   cycle while busy.
//   the result is shown in the cycle after the last busy cycle.
// Reset: synchronous, active low; the stack comes up empty and no word is
//   pending. Entries above the fill count hold no defined value.
module stack_engine_with_sort_and_reverse_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_read_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_fill_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  se_pkg::ccmd_t     run_cmd_r, run_cmd_nxt;
  logic              phase_r, phase_nxt;
  se_pkg::cnt_t      steps_r, steps_nxt;
  se_pkg::cnt_t      count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  se_pkg::word_t     out_read_value_r, out_read_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [4:0]        out_fill_count_r, out_fill_count_nxt;

  se_pkg::cell_ctl_t ctl;
  se_pkg::cnt_t      rd_idx;
  se_pkg::word_t     rd_bus;
  se_pkg::cell_nb_t  nb [se_pkg::DEPTH];
  se_pkg::word_t     rd_part [se_pkg::DEPTH];

  logic              is_full;
  logic              is_empty;

  assign is_full  = (count_r == se_pkg::CW'(se_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  // middle entry for read middle, top entry otherwise
  assign rd_idx = (in_operation == se_pkg::OP_READ_MID) ? (count_r >> 1) :
                                                          (count_r - 1'b1);

  genvar g;
  generate
    for (g = 0; g < se_pkg::DEPTH; g++) begin : g_cell
      se_pkg::cell_nb_t lo_in;
      se_pkg::cell_nb_t hi_in;
      if (g == 0) begin : g_lo0
        assign lo_in = '0;
      end else begin : g_lo
        assign lo_in = nb[g-1];
      end
      if (g == se_pkg::DEPTH - 1) begin : g_hi0
        assign hi_in = '0;
      end else begin : g_hi
        assign hi_in = nb[g+1];
      end
      se_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .idx     (se_pkg::IW'(g)),
        .lo      (lo_in),
        .hi      (hi_in),
        .rd_idx  (rd_idx),
        .me      (nb[g]),
        .rd_data (rd_part[g])
      );
    end
  endgenerate

  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < se_pkg::DEPTH; k++) begin
      rd_bus = rd_bus | rd_part[k];
    end
  end

  always_comb begin
    state_nxt          = state_r;
    run_cmd_nxt        = run_cmd_r;
    phase_nxt          = phase_r;
    steps_nxt          = steps_r;
    count_nxt          = count_r;
    out_valid_nxt      = 1'b0;
    out_read_value_nxt = out_read_value_r;
    out_status_nxt     = out_status_r;
    out_fill_count_nxt = out_fill_count_r;
    ctl.cmd            = se_pkg::CC_HOLD;
    ctl.phase          = phase_r;
    ctl.set_mov        = 1'b0;
    ctl.count          = count_r;
    ctl.value          = in_value;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_read_value_nxt = '0;
          out_status_nxt     = se_pkg::ST_OK;
          phase_nxt          = 1'b0;
          unique case (in_operation)
            se_pkg::OP_PUSH, se_pkg::OP_INS_BOTTOM: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = se_pkg::ST_FULL;
              end else begin
                ctl.cmd   = (in_operation == se_pkg::OP_PUSH) ?
                            se_pkg::CC_PUSH : se_pkg::CC_SHIFT_UP;
                count_nxt = count_r + 1'b1;
              end
            end
            se_pkg::OP_INS_SORTED: begin
              if (is_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = se_pkg::ST_FULL;
              end else begin
                ctl.cmd     = se_pkg::CC_PUSH;
                ctl.set_mov = 1'b1;
                count_nxt   = count_r + 1'b1;
                steps_nxt   = count_r + 1'b1;
                run_cmd_nxt = se_pkg::CC_INS;
                state_nxt   = S_RUN;
              end
            end
            se_pkg::OP_POP: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = se_pkg::ST_EMPTY;
              end else begin
                out_read_value_nxt = rd_bus;
                count_nxt          = count_r - 1'b1;
              end
            end
            se_pkg::OP_READ_MID: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = se_pkg::ST_EMPTY;
              end else begin
                out_read_value_nxt = rd_bus;
              end
            end
            se_pkg::OP_REVERSE: begin
              ctl.cmd     = se_pkg::CC_TAG;
              steps_nxt   = count_r;
              run_cmd_nxt = se_pkg::CC_REV;
              state_nxt   = S_RUN;
            end
            se_pkg::OP_SORT: begin
              steps_nxt   = count_r;
              run_cmd_nxt = se_pkg::CC_SORT;
              state_nxt   = S_RUN;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_fill_count_nxt = 5'(count_nxt);
        end
      end
      S_RUN: begin
        if (steps_r == '0) begin
          out_valid_nxt      = 1'b1;
          out_read_value_nxt = '0;
          out_status_nxt     = se_pkg::ST_OK;
          out_fill_count_nxt = 5'(count_r);
          state_nxt          = S_IDLE;
        end else begin
          ctl.cmd   = run_cmd_r;
          phase_nxt = ~phase_r;
          steps_nxt = steps_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_cmd_r   <= se_pkg::CC_HOLD;
      phase_r     <= 1'b0;
      steps_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_cmd_r   <= run_cmd_nxt;
      phase_r     <= phase_nxt;
      steps_r     <= steps_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_read_value_r <= out_read_value_nxt;
    out_status_r     <= out_status_nxt;
    out_fill_count_r <= out_fill_count_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_count_r;

endmodule

[hdl/se_chk.sv]
module se_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [2:0]         in_operation,
  input logic signed [31:0] in_value,
  input logic               out_valid,
  input logic signed [31:0] out_read_value,
  input logic [1:0]         out_status,
  input logic [4:0]         out_fill_count
);

  logic unused_ok;
  assign unused_ok = ^{in_value, out_fill_count};

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == se_pkg::ST_OK || out_status == se_pkg::ST_EMPTY ||
                   out_status == se_pkg::ST_FULL))
    else $error("result carries an unused status code");

  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == se_pkg::OP_PUSH || in_operation == se_pkg::OP_POP))
    |=> (out_valid && !busy))
    else $error("push or pop word not answered in the next cycle");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != se_pkg::ST_OK) |-> (out_read_value == '0))
    else $error("failed operation returned a nonzero value");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while engine still busy");

endmodule

bind stack_engine_with_sort_and_reverse_top se_chk u_se_chk (.*);
